// ===== rtl/core/scan_disk_scheduler_unit_assert.svh =====
// Assertion macros for the SCAN disk scheduler.
// Included by the RTL files that carry concurrent checks; needs clk and rst in scope.
`ifndef SCAN_DISK_SCHEDULER_UNIT_ASSERT_SVH
`define SCAN_DISK_SCHEDULER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SDS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sds assertion failed");
`define SDS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sds assertion failed");
`else
`define SDS_ASSERT_IMP(lbl, ante, cons)
`define SDS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/sds_pkg.sv =====
// Shared constants, state codes and controller/datapath interface types
// for the SCAN disk scheduler. No dependencies.
`default_nettype none
package sds_pkg;

  localparam int MAX_REQUESTS = 32;
  localparam int TRACK_BITS   = 16;
  localparam int ADDR_W       = $clog2(MAX_REQUESTS);
  localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
  localparam int SEEK_W       = TRACK_BITS + 1;
  localparam int TC_W         = TRACK_BITS + 1;
  localparam int TRACK_COUNT_RESET = 200;
  localparam logic [TRACK_BITS-1:0] TOP_RESET = TRACK_BITS'(TRACK_COUNT_RESET - 1);

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_START = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LOAD   = 6'b000010,
    S_SEARCH = 6'b000100,
    S_FIRST  = 6'b001000,
    S_ENDPT  = 6'b010000,
    S_SECOND = 6'b100000
  } state_t;

  typedef struct packed {
    logic capture;
    logic insert;
    logic search;
    logic emit_req;
    logic emit_end;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic have_item;
    logic final_item;
    logic second_empty;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/core/sds_ctrl.sv =====
// Sequencing controller for the SCAN disk scheduler.
// Depends on sds_pkg; drives commands into sds_datapath.
`default_nettype none
module sds_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  input  wire              kind,
  input  sds_pkg::status_t status,
  output sds_pkg::cmd_t    cmd,
  output logic             busy
);

  sds_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sds_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      sds_pkg::S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = (kind == sds_pkg::KIND_START) ? sds_pkg::S_SEARCH : sds_pkg::S_LOAD;
        end
      end
      sds_pkg::S_LOAD: begin
        cmd.insert = 1'b1;
        state_next = sds_pkg::S_IDLE;
      end
      sds_pkg::S_SEARCH: begin
        cmd.search = 1'b1;
        state_next = sds_pkg::S_FIRST;
      end
      sds_pkg::S_FIRST: begin
        if (status.have_item) begin
          cmd.emit_req = 1'b1;
        end else begin
          state_next = sds_pkg::S_ENDPT;
        end
      end
      sds_pkg::S_ENDPT: begin
        cmd.emit_end = 1'b1;
        if (status.second_empty) begin
          cmd.finish = 1'b1;
          state_next = sds_pkg::S_IDLE;
        end else begin
          state_next = sds_pkg::S_SECOND;
        end
      end
      sds_pkg::S_SECOND: begin
        cmd.emit_req = 1'b1;
        if (status.final_item) begin
          cmd.finish = 1'b1;
          state_next = sds_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sds_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state != sds_pkg::S_IDLE);

endmodule
`default_nettype wire

// ===== rtl/core/sds_datapath.sv =====
// Datapath for the SCAN disk scheduler: sorted request store, scan index,
// head position, seek total and result registers. Depends on sds_pkg.
`default_nettype none
`include "scan_disk_scheduler_unit_assert.svh"
module sds_datapath (
  input  wire                                  clk,
  input  wire                                  rst,
  input  sds_pkg::cmd_t                        cmd,
  output sds_pkg::status_t                     status,
  input  wire                                  cfg_wen,
  input  wire  [sds_pkg::TC_W-1:0]             cfg_wdata,
  input  wire  [sds_pkg::TRACK_BITS-1:0]       track,
  input  wire  [sds_pkg::TRACK_BITS-1:0]       prev_track,
  output logic                                 strobe,
  output logic [sds_pkg::TRACK_BITS-1:0]       visited_track,
  output logic                                 end_point,
  output logic [sds_pkg::SEEK_W-1:0]           seek_total,
  output logic                                 last
);

  localparam int N  = sds_pkg::MAX_REQUESTS;
  localparam int TB = sds_pkg::TRACK_BITS;
  localparam int CW = sds_pkg::CNT_W;
  localparam int AW = sds_pkg::ADDR_W;
  localparam int SW = sds_pkg::SEEK_W;
  localparam int TC_M1_W = sds_pkg::TC_W;

  logic [TB-1:0] store [N];
  logic [TB-1:0] store_next [N];
  logic [CW-1:0] cnt;
  logic [TB-1:0] top;
  logic [TB-1:0] trk;
  logic [TB-1:0] prev;
  logic [TB-1:0] pos;
  logic [SW-1:0] seek;
  logic [CW-1:0] idx;
  logic [CW-1:0] low;
  logic          asc;
  logic          second;

  logic [TC_M1_W-1:0] tc_m1;
  logic [TB-1:0] top_next;
  logic [TB-1:0] trk_clamped;
  logic [N-1:0]  gt_ins;
  logic [N-1:0]  gt_head;
  logic [CW-1:0] low_next;
  logic [AW-1:0] rd_addr;
  logic [TB-1:0] rd_val;
  logic [TB-1:0] target;
  logic [TB-1:0] delta;
  logic [CW-1:0] idx_step;

  // top track from the configured count, saturated to the track range
  always_comb begin
    tc_m1    = (cfg_wdata == '0) ? '0 : cfg_wdata - TC_M1_W'(1);
    top_next = (tc_m1[TB] != 1'b0) ? {TB{1'b1}} : tc_m1[TB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top <= sds_pkg::TOP_RESET;
    end else if (cfg_wen) begin
      top <= top_next;
    end
  end

  assign trk_clamped = (track > top) ? top : track;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      trk  <= trk_clamped;
      prev <= prev_track;
    end
  end

  // sorted insertion: entries above the new track move up one place
  always_comb begin
    for (int i = 0; i < N; i++) begin
      gt_ins[i]  = (CW'(i) < cnt) && (store[i] > trk);
      gt_head[i] = (CW'(i) >= cnt) || (store[i] > trk);
    end
    for (int i = 0; i < N; i++) begin
      if (i > 0 && gt_ins[(i > 0) ? i - 1 : 0]) begin
        store_next[i] = store[(i > 0) ? i - 1 : 0];
      end else if (gt_ins[i] || CW'(i) == cnt) begin
        store_next[i] = trk;
      end else begin
        store_next[i] = store[i];
      end
    end
    low_next = CW'(N);
    for (int i = N - 1; i >= 0; i--) begin
      if (gt_head[i]) begin
        low_next = CW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert && cnt != CW'(N)) begin
      for (int i = 0; i < N; i++) begin
        store[i] <= store_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.finish) begin
      cnt <= '0;
    end else if (cmd.insert && cnt != CW'(N)) begin
      cnt <= cnt + CW'(1);
    end
  end

  // scan walk
  assign rd_addr  = asc ? idx[AW-1:0] : AW'(idx - CW'(1));
  assign rd_val   = store[rd_addr];
  assign target   = cmd.emit_end ? (asc ? top : '0) : rd_val;
  assign delta    = (pos > target) ? pos - target : target - pos;
  assign idx_step = asc ? idx + CW'(1) : idx - CW'(1);

  assign status.have_item    = asc ? (idx < cnt) : (idx != '0);
  assign status.final_item   = second && (asc ? (idx_step == cnt) : (idx == CW'(1)));
  assign status.second_empty = asc ? (low == '0) : (low == cnt);

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      asc    <= !(prev > trk);
      idx    <= low_next;
      low    <= low_next;
      pos    <= trk;
      seek   <= '0;
      second <= 1'b0;
    end else if (cmd.emit_req) begin
      idx  <= idx_step;
      pos  <= target;
      seek <= seek + SW'(delta);
    end else if (cmd.emit_end) begin
      asc    <= !asc;
      idx    <= low;
      pos    <= target;
      seek   <= seek + SW'(delta);
      second <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_req || cmd.emit_end;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_req || cmd.emit_end) begin
      visited_track <= target;
      end_point     <= cmd.emit_end;
      seek_total    <= seek + SW'(delta);
      last          <= cmd.emit_end ? status.second_empty : status.final_item;
    end
  end

  `SDS_ASSERT_NXT(a_last_ends_run, strobe && last, !strobe)
  `SDS_ASSERT_NXT(a_full_drops, cmd.insert && cnt == CW'(N), cnt == CW'(N))
  `SDS_ASSERT_IMP(a_end_at_edge, strobe && end_point, visited_track == '0 || visited_track == top)
  `SDS_ASSERT_IMP(a_count_bound, 1'b1, cnt <= CW'(N))

endmodule
`default_nettype wire

// ===== rtl/core/scan_disk_scheduler_unit.sv =====
// SCAN (elevator) disk scheduler, top level.
// Instantiates sds_ctrl and sds_datapath; depends on sds_pkg.
`default_nettype none
// A transfer is taken when start is high and busy is low: kind 0 loads one
// request track into the sorted store (32 entries, extras dropped), kind 1
// starts a scan from the given head. A load keeps busy high for one cycle.
// A scan keeps busy high through the search, the requests of the first side,
// a step to find the first side done, the end turn point and the requests of
// the second side; results come on strobe one per cycle, bar the idle step
// before the end turn point, the last in the cycle in which busy falls, and
// cannot be held off.
module scan_disk_scheduler_unit (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  start,
  output logic                                 busy,
  input  wire                                  kind,
  input  wire  [sds_pkg::TRACK_BITS-1:0]       track,
  input  wire  [sds_pkg::TRACK_BITS-1:0]       prev_track,
  input  wire                                  cfg_wen,
  input  wire  [sds_pkg::TC_W-1:0]             cfg_wdata,
  output logic                                 strobe,
  output logic [sds_pkg::TRACK_BITS-1:0]       visited_track,
  output logic                                 end_point,
  output logic [sds_pkg::SEEK_W-1:0]           seek_total,
  output logic                                 last
);

  sds_pkg::cmd_t    cmd;
  sds_pkg::status_t status;

  sds_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .kind   (kind),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  sds_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .track         (track),
    .prev_track    (prev_track),
    .strobe        (strobe),
    .visited_track (visited_track),
    .end_point     (end_point),
    .seek_total    (seek_total),
    .last          (last)
  );

endmodule
`default_nettype wire

// ===== verif/scan_disk_scheduler_unit_tb.sv =====
// Testbench for scan_disk_scheduler_unit: directed table, then random load/scan runs
// checked against an in-bench SCAN predictor. Depends on sds_pkg and the RTL only.
`timescale 1ns / 1ps
module scan_disk_scheduler_unit_tb;

  localparam int TB = sds_pkg::TRACK_BITS;

  typedef struct packed {
    logic [TB-1:0]             trk;
    logic                      endp;
    logic [sds_pkg::SEEK_W-1:0] seek;
    logic                      last;
  } visit_t;

  typedef struct packed {
    logic          kind;
    logic [TB-1:0] trk;
    logic [TB-1:0] prv;
    logic          typed;
    visit_t        want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic kind = 1'b0;
  logic [TB-1:0] track = '0;
  logic [TB-1:0] prev_track = '0;
  logic cfg_wen = 1'b0;
  logic [sds_pkg::TC_W-1:0] cfg_wdata = '0;
  logic busy, strobe, end_point, last;
  logic [TB-1:0] visited_track;
  logic [sds_pkg::SEEK_W-1:0] seek_total;

  // predictor state
  logic [sds_pkg::TC_W-1:0] disk_tracks = sds_pkg::TC_W'(sds_pkg::TRACK_COUNT_RESET);
  logic [TB-1:0] req_store[$];
  visit_t run_plan[$];
  visit_t visit_q[$];
  int head_pos, seek_sum, emitted, run_len;

  int errors = 0;
  int items_sent = 0;
  int burst_left = 0;
  int tc_corners [7] = '{0, 1, 2, 65536, 131071, 100000, 200};
  dir_row_t dir_rows[$];
  visit_t want;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  scan_disk_scheduler_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .track         (track),
    .prev_track    (prev_track),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .strobe        (strobe),
    .visited_track (visited_track),
    .end_point     (end_point),
    .seek_total    (seek_total),
    .last          (last)
  );

  task automatic report_mismatch(string msg);
    $display("ERROR %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [TB-1:0] top_of_disk();
    logic [sds_pkg::TC_W-1:0] t;
    t = (disk_tracks == 0) ? '0 : disk_tracks - 1'b1;
    return (t > {1'b0, {TB{1'b1}}}) ? {TB{1'b1}} : t[TB-1:0];
  endfunction

  function automatic logic [TB-1:0] saturate(logic [TB-1:0] t);
    logic [TB-1:0] top;
    top = top_of_disk();
    return (t > top) ? top : t;
  endfunction

  // sorted insert; loads beyond capacity are dropped
  function automatic void store_request(logic [TB-1:0] t_in);
    logic [TB-1:0] t, tmp;
    int p;
    if (req_store.size() >= sds_pkg::MAX_REQUESTS) return;
    t = saturate(t_in);
    req_store.push_back(t);
    p = req_store.size() - 1;
    while (p > 0 && req_store[p-1] > t) begin
      tmp = req_store[p-1];
      req_store[p-1] = req_store[p];
      req_store[p] = tmp;
      p--;
    end
  endfunction

  function automatic void add_stop(int trk, logic endp);
    visit_t v;
    seek_sum += (trk > head_pos) ? trk - head_pos : head_pos - trk;
    head_pos = trk;
    v.trk  = trk[TB-1:0];
    v.endp = endp;
    v.seek = seek_sum[sds_pkg::SEEK_W-1:0];
    v.last = (emitted == run_len - 1);
    run_plan.push_back(v);
    emitted++;
  endfunction

  function automatic void plan_scan(logic [TB-1:0] head_in, logic [TB-1:0] prev_in);
    int head, low, n_req, i;
    logic [TB-1:0] top;
    top = top_of_disk();
    head = saturate(head_in);
    n_req = req_store.size();
    head_pos = head;
    seek_sum = 0;
    emitted = 0;
    run_len = n_req + 1;
    run_plan.delete();
    low = 0;
    while (low < n_req && req_store[low] <= head) low++;
    if (prev_in > head) begin
      for (i = low - 1; i >= 0; i--) add_stop(req_store[i], 1'b0);
      add_stop(0, 1'b1);
      for (i = low; i < n_req; i++) add_stop(req_store[i], 1'b0);
    end else begin
      for (i = low; i < n_req; i++) add_stop(req_store[i], 1'b0);
      add_stop(top, 1'b1);
      for (i = low - 1; i >= 0; i--) add_stop(req_store[i], 1'b0);
    end
    req_store.delete();
  endfunction

  function automatic dir_row_t mk_row(logic k, int t, int p, logic typed,
                                      int wtrk, logic wend, int wseek);
    dir_row_t r;
    r.kind       = k;
    r.trk        = t[TB-1:0];
    r.prv        = p[TB-1:0];
    r.typed      = typed;
    r.want.trk   = wtrk[TB-1:0];
    r.want.endp  = wend;
    r.want.seek  = wseek[sds_pkg::SEEK_W-1:0];
    r.want.last  = typed;
    return r;
  endfunction

  // sender: bursts of random length separated by random gaps
  task automatic send_item(logic k, logic [TB-1:0] t, logic [TB-1:0] p,
                           logic typed, visit_t typed_want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
      end
      burst_left = $urandom_range(1, 20);
    end
    @(negedge clk);
    start      <= 1'b1;
    kind       <= k;
    track      <= t;
    prev_track <= p;
    do @(posedge clk); while (busy);
    burst_left--;
    items_sent++;
    if (k == sds_pkg::KIND_LOAD) begin
      store_request(t);
    end else begin
      plan_scan(t, p);
      if (typed) begin
        visit_q.push_back(typed_want);
      end else begin
        foreach (run_plan[i]) visit_q.push_back(run_plan[i]);
      end
    end
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    start <= 1'b0;
    while (visit_q.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_tracks(logic [sds_pkg::TC_W-1:0] v);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    disk_tracks = v;
  endtask

  task automatic random_run();
    int nload;
    logic [TB-1:0] top, head, prv, t;
    top = top_of_disk();
    nload = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 12);
    head = ($urandom_range(0, 4) == 0) ? TB'($urandom) : TB'($urandom_range(0, top));
    repeat (nload) begin
      case ($urandom_range(0, 5))
        0:       t = TB'($urandom);
        1:       t = head;
        default: t = TB'($urandom_range(0, top));
      endcase
      send_item(sds_pkg::KIND_LOAD, t, TB'($urandom), 1'b0, '0);
    end
    case ($urandom_range(0, 4))
      0:       prv = head;
      1:       prv = TB'($urandom);
      2, 3:    prv = (head == {TB{1'b1}}) ? head : TB'($urandom_range(head + 1, 65535));
      default: prv = TB'($urandom_range(0, head));
    endcase
    send_item(sds_pkg::KIND_START, head, prv, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (visit_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer: track %0d seek %0d",
                                  visited_track, seek_total));
      end else begin
        want = visit_q.pop_front();
        if (visited_track !== want.trk)
          report_mismatch($sformatf("visited_track %0d, want %0d", visited_track, want.trk));
        if (end_point !== want.endp)
          report_mismatch($sformatf("end_point %0b, want %0b", end_point, want.endp));
        if (seek_total !== want.seek)
          report_mismatch($sformatf("seek_total %0d, want %0d", seek_total, want.seek));
        if (last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", last, want.last));
      end
    end
  end

  initial begin
    int phase;
    dir_row_t row;
    // empty store at start: single end point, 200 tracks after reset
    dir_rows.push_back(mk_row(sds_pkg::KIND_START, 50, 40, 1'b1, 199, 1'b1, 149));
    dir_rows.push_back(mk_row(sds_pkg::KIND_START, 50, 60, 1'b1, 0, 1'b1, 50));
    dir_rows.push_back(mk_row(sds_pkg::KIND_START, 65535, 0, 1'b1, 199, 1'b1, 0));
    dir_rows.push_back(mk_row(sds_pkg::KIND_START, 0, 65535, 1'b1, 0, 1'b1, 0));
    // upward, saturated load, duplicates equal to the head
    dir_rows.push_back(mk_row(sds_pkg::KIND_LOAD, 0, 0, 1'b0, 0, 1'b0, 0));
    dir_rows.push_back(mk_row(sds_pkg::KIND_LOAD, 65535, 65535, 1'b0, 0, 1'b0, 0));
    dir_rows.push_back(mk_row(sds_pkg::KIND_LOAD, 100, 0, 1'b0, 0, 1'b0, 0));
    dir_rows.push_back(mk_row(sds_pkg::KIND_LOAD, 100, 0, 1'b0, 0, 1'b0, 0));
    dir_rows.push_back(mk_row(sds_pkg::KIND_LOAD, 30, 0, 1'b0, 0, 1'b0, 0));
    dir_rows.push_back(mk_row(sds_pkg::KIND_LOAD, 150, 0, 1'b0, 0, 1'b0, 0));
    dir_rows.push_back(mk_row(sds_pkg::KIND_START, 100, 0, 1'b0, 0, 1'b0, 0));
    // downward with a request equal to the head
    dir_rows.push_back(mk_row(sds_pkg::KIND_LOAD, 10, 0, 1'b0, 0, 1'b0, 0));
    dir_rows.push_back(mk_row(sds_pkg::KIND_LOAD, 100, 0, 1'b0, 0, 1'b0, 0));
    dir_rows.push_back(mk_row(sds_pkg::KIND_LOAD, 180, 0, 1'b0, 0, 1'b0, 0));
    dir_rows.push_back(mk_row(sds_pkg::KIND_START, 100, 65535, 1'b0, 0, 1'b0, 0));
    // empty first side, both directions
    dir_rows.push_back(mk_row(sds_pkg::KIND_LOAD, 5, 0, 1'b0, 0, 1'b0, 0));
    dir_rows.push_back(mk_row(sds_pkg::KIND_LOAD, 7, 0, 1'b0, 0, 1'b0, 0));
    dir_rows.push_back(mk_row(sds_pkg::KIND_START, 100, 0, 1'b0, 0, 1'b0, 0));
    dir_rows.push_back(mk_row(sds_pkg::KIND_LOAD, 190, 0, 1'b0, 0, 1'b0, 0));
    dir_rows.push_back(mk_row(sds_pkg::KIND_START, 10, 20, 1'b0, 0, 1'b0, 0));

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_item(row.kind, row.trk, row.prv, row.typed, row.want);
    end

    phase = 0;
    while (items_sent < 250) begin
      wait_quiet();
      if (phase < 7)
        write_tracks(sds_pkg::TC_W'(tc_corners[phase]));
      else if ($urandom_range(0, 3) == 0)
        write_tracks(sds_pkg::TC_W'($urandom_range(0, 131071)));
      else
        write_tracks(sds_pkg::TC_W'($urandom_range(2, 1000)));
      repeat ($urandom_range(1, 3)) random_run();
      phase++;
    end

    wait_quiet();
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #(3_000_000);
    $display("status: fail");
    $finish;
  end

endmodule

// ===== scan_disk_scheduler_unit.f =====
+incdir+rtl/core
rtl/core/sds_pkg.sv
rtl/core/sds_ctrl.sv
rtl/core/sds_datapath.sv
rtl/core/scan_disk_scheduler_unit.sv
verif/scan_disk_scheduler_unit_tb.sv
